>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL modules.
// Each module that asserts has clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/lssp_pkg.sv
package lssp_pkg;

  // Sequence and table sizing
  localparam int MAX_LEN = 256;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int LEN_W   = $clog2(MAX_LEN + 1);

  // Field widths
  localparam int DATA_W  = 32;
  localparam int SUM_W   = 40;
  localparam int REM_W   = SUM_W + 1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the input item
    logic prep;    // clear on first, form the new prefix sum
    logic scan;    // step the table scan
    logic insert;  // add the prefix sum to the table if new
    logic emit;    // load the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic skip;       // sequence is full, no table work for this item
    logic scan_busy;  // reads or compares still outstanding
    logic out_free;   // output register can take a result
  } status_t;

endpackage

>>> rtl/core/longest_subarray_sum_prefix_map.sv
// Longest run with a given sum, found through a table of first prefix positions.
// Each accepted item steps through prep, a scan of the n distinct prefix sums stored
// (n <= 255) reading one entry a cycle, insert and output; a full sequence skips the
// scan and insert. A new item is taken only after the last result is loaded.
// Reset (rst, synchronous): target 0, sum/position/best/count/overflow cleared, no
// output pending; table contents stay undefined and are never read before written.
module longest_subarray_sum_prefix_map (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [31:0] cfg_wdata,     // target_sum
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,       // [31:0] value
  input  logic        s_tuser,       // [0] first
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,       // [8:0] best_length, [15:9] zero
  output logic        m_tuser,       // [0] overflow
  output logic        m_tlast
);

  lssp_pkg::cmd_t    cmd;
  lssp_pkg::status_t status;
  logic [lssp_pkg::LEN_W-1:0] out_best;

  lssp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lssp_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .in_value     (s_tdata),
    .in_first     (s_tuser),
    .in_last      (s_tlast),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_best     (out_best),
    .out_last     (m_tlast),
    .out_overflow (m_tuser)
  );

  // Pad the result to whole bytes
  assign m_tdata = {{(16 - lssp_pkg::LEN_W){1'b0}}, out_best};

endmodule

>>> rtl/core/lssp_dp.sv
module lssp_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wen,
  input  logic [lssp_pkg::DATA_W-1:0] cfg_wdata,
  input  logic [lssp_pkg::DATA_W-1:0] in_value,
  input  logic                       in_first,
  input  logic                       in_last,
  input  lssp_pkg::cmd_t             cmd,
  output lssp_pkg::status_t          status,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lssp_pkg::LEN_W-1:0] out_best,
  output logic                       out_last,
  output logic                       out_overflow
);

  localparam int AW = lssp_pkg::ADDR_W;
  localparam int LW = lssp_pkg::LEN_W;
  localparam int DW = lssp_pkg::DATA_W;
  localparam int SW = lssp_pkg::SUM_W;
  localparam int RW = lssp_pkg::REM_W;

  // Configuration and sequence state
  logic signed [DW-1:0] target_sum;
  logic [SW-1:0]        running_sum;
  logic [LW-1:0]        position;
  logic [LW-1:0]        best;
  logic [LW-1:0]        entry_count;
  logic                 overflowed;

  // Captured item and per-item working registers
  logic [DW-1:0] item_value;
  logic          item_first;
  logic          item_last;
  logic [AW-1:0] cur_pos;
  logic [RW-1:0] rem;
  logic          seen;

  // Scan pipeline
  logic [LW-1:0] rd_idx;
  logic          cmp_valid;
  logic [SW-1:0] rd_key;
  logic [AW-1:0] rd_fp;

  // Prefix table: key and first position per entry
  logic [SW+AW-1:0] table_mem [lssp_pkg::MAX_LEN];

  logic [SW-1:0] base_sum;
  logic [LW-1:0] base_pos;
  logic [LW-1:0] base_best;
  logic [LW-1:0] base_cnt;
  logic          base_ovf;
  logic          skip;
  logic [SW-1:0] sum_new;
  logic [SW-1:0] tgt_ext;
  logic [LW-1:0] run_len;
  logic [LW-1:0] best_prep;
  logic          rd_more;
  logic          key_hit;
  logic          key_seen;
  logic [LW-1:0] tbl_len;

  // Start from a cleared sequence when the item opens one
  always_comb begin
    base_sum  = item_first ? '0 : running_sum;
    base_pos  = item_first ? '0 : position;
    base_best = item_first ? '0 : best;
    base_cnt  = item_first ? '0 : entry_count;
    base_ovf  = item_first ? 1'b0 : overflowed;
    skip      = (base_pos >= LW'(lssp_pkg::MAX_LEN));
    sum_new   = base_sum + {{(SW-DW){item_value[DW-1]}}, item_value};
    tgt_ext   = {{(SW-DW){target_sum[DW-1]}}, target_sum};
    run_len   = base_pos + LW'(1);
    best_prep = base_best;
    if ((sum_new == tgt_ext) && (run_len > base_best)) begin
      best_prep = run_len;
    end
  end

  // Compare the registered table entry against remainder and sum
  always_comb begin
    rd_more  = (rd_idx < entry_count);
    key_hit  = ({rd_key[SW-1], rd_key} == rem);
    key_seen = (rd_key == running_sum);
    tbl_len  = LW'(cur_pos) - LW'(rd_fp);
  end

  assign status.skip      = skip;
  assign status.scan_busy = rd_more || cmp_valid;
  assign status.out_free  = !out_valid || out_ready;

  // Hold the target register
  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= '0;
    end else if (cfg_wen) begin
      target_sum <= cfg_wdata;
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_value <= in_value;
      item_first <= in_first;
      item_last  <= in_last;
    end
  end

  // Advance sequence state through prep, scan and insert
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      position    <= '0;
      best        <= '0;
      entry_count <= '0;
      overflowed  <= 1'b0;
      rd_idx      <= '0;
      cmp_valid   <= 1'b0;
      seen        <= 1'b0;
    end else begin
      if (cmd.prep) begin
        entry_count <= base_cnt;
        overflowed  <= base_ovf | skip;
        rd_idx      <= '0;
        cmp_valid   <= 1'b0;
        seen        <= 1'b0;
        if (skip) begin
          running_sum <= base_sum;
          position    <= base_pos;
          best        <= base_best;
        end else begin
          running_sum <= sum_new;
          position    <= run_len;
          best        <= best_prep;
        end
      end
      if (cmd.scan) begin
        cmp_valid <= rd_more;
        if (rd_more) begin
          rd_idx <= rd_idx + LW'(1);
        end
        if (cmp_valid) begin
          if (key_hit && (tbl_len > best)) begin
            best <= tbl_len;
          end
          if (key_seen) begin
            seen <= 1'b1;
          end
        end
      end
      if (cmd.insert && !seen) begin
        entry_count <= entry_count + LW'(1);
      end
    end
  end

  // Latch item position and remainder for the scan
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      cur_pos <= base_pos[AW-1:0];
      rem     <= {sum_new[SW-1], sum_new} - {{(RW-DW){target_sum[DW-1]}}, target_sum};
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.insert && !seen) begin
      table_mem[entry_count[AW-1:0]] <= {running_sum, cur_pos};
    end
    if (cmd.scan && rd_more) begin
      {rd_key, rd_fp} <= table_mem[rd_idx[AW-1:0]];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_best     <= best;
      out_last     <= item_last;
      out_overflow <= overflowed;
    end
  end

`include "assert_macros.svh"

  `ASSERT_CLK(a_cnt_le_pos, entry_count <= position, "table holds more entries than items")
  `ASSERT_CLK(a_best_le_pos, best <= position, "best run longer than sequence")
  `ASSERT_CLK(a_insert_idle, cmd.insert |-> !status.scan_busy, "insert while scan busy")

endmodule

>>> rtl/core/lssp_ctrl.sv
module lssp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lssp_pkg::status_t status,
  output lssp_pkg::cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PREP   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_INSERT = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // Sequence one item through prep, table scan, insert and output; a full sequence skips scan and insert
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = status.skip ? S_OUT : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (!status.scan_busy) begin
          state_next = S_INSERT;
        end
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`include "assert_macros.svh"

  `ASSERT_CLK(a_accept_prep, (in_valid && in_ready) |=> (state == S_PREP), "item not prepared")
  `ASSERT_CLK(a_emit_free, cmd.emit |-> status.out_free, "result loaded over pending one")
  `ASSERT_CLK(a_skip_no_scan, (cmd.prep && status.skip) |=> (state == S_OUT), "full sequence scanned")

endmodule

>>> verif/longest_subarray_sum_prefix_map_tb.sv
module longest_subarray_sum_prefix_map_tb;

  localparam int CYCLE_LIMIT  = 1500000;
  localparam int DRAIN_CYCLES = 270;
  localparam int IDLE_PCT     = 14;
  localparam int STALL_LEN    = 400;

  typedef struct packed {
    logic [lssp_pkg::LEN_W-1:0] best_len;
    logic                       is_last;
    logic                       ovf;
  } run_result_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_wen   = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata   = '0;
  logic        s_tuser   = 1'b0;
  logic        s_tlast   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  longest_subarray_sum_prefix_map dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // Shared run control
  run_result_t pending_results[$];
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int          stall_left     = 0;
  bit          quiet          = 1'b0;

  // Prefix-sum tracker state
  logic signed [31:0]         goal_sum   = '0;
  logic [lssp_pkg::SUM_W-1:0] prefix_acc = '0;
  int                         run_pos    = 0;
  int                         run_best   = 0;
  int                         key_count  = 0;
  bit                         run_full   = 1'b0;
  logic [lssp_pkg::SUM_W-1:0] key_store [lssp_pkg::MAX_LEN];
  int                         key_first [lssp_pkg::MAX_LEN];

  initial forever #5 clk = ~clk;

  // Advance the tracker by one item and return the length it should report
  function automatic run_result_t predict_best_run(input logic [31:0] v, input logic fm,
                                                   input logic lm);
    longint      sum_w;
    longint      rem_w;
    longint      key_w;
    bit          seen;
    run_result_t r;
    if (fm) begin
      prefix_acc = '0;
      run_pos    = 0;
      run_best   = 0;
      key_count  = 0;
      run_full   = 1'b0;
    end
    if (run_pos >= lssp_pkg::MAX_LEN) begin
      run_full = 1'b1;
    end else begin
      prefix_acc = prefix_acc + {{(lssp_pkg::SUM_W-32){v[31]}}, v};
      sum_w = longint'($signed(prefix_acc));
      // remainder kept at full width, never cut back to 32 bits
      rem_w = sum_w - longint'(goal_sum);
      seen  = 1'b0;
      if (sum_w == longint'(goal_sum) && run_pos + 1 > run_best) run_best = run_pos + 1;
      for (int j = 0; j < key_count; j++) begin
        key_w = longint'($signed(key_store[j]));
        if (key_w == rem_w && run_pos - key_first[j] > run_best)
          run_best = run_pos - key_first[j];
        if (key_w == sum_w) seen = 1'b1;
      end
      // keep only the first position of each prefix sum
      if (!seen && key_count < lssp_pkg::MAX_LEN) begin
        key_store[key_count] = prefix_acc;
        key_first[key_count] = run_pos;
        key_count++;
      end
      run_pos++;
    end
    r.best_len = run_best[lssp_pkg::LEN_W-1:0];
    r.is_last  = lm;
    r.ovf      = run_full;
    return r;
  endfunction

  // Draw a value: mostly small so that runs match, sometimes the target or an extreme
  function automatic logic [31:0] pick_value(input bit noisy);
    if (noisy) return $urandom;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return 32'($urandom_range(8)) - 32'd4;
      6: return goal_sum;
      7: return -goal_sum;
      8: return $urandom;
      default: begin
        case ($urandom_range(3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
    endcase
  endfunction

  // Offer one item, with a random gap first, and record its expected result
  task automatic send_item(input logic [31:0] v, input logic fm, input logic lm);
    int gap;
    gap = 0;
    @(negedge clk);
    if (!quiet) while ($urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tuser  <= fm;
    s_tlast  <= lm;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(predict_best_run(v, fm, lm));
  endtask

  // Drop valid and hold off until every pending result has come back
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_target(input logic [31:0] v);
    wait_drained();
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    goal_sum   = v;
    @(negedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // Short runs with random content; a few broken ones (missing first or last marks)
  task automatic send_random_runs(input int n_items);
    int sent;
    int len;
    bit noisy;
    sent = 0;
    while (sent < n_items) begin
      len   = ($urandom_range(19) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
      noisy = ($urandom_range(9) == 0);
      for (int k = 0; k < len; k++)
        send_item(pick_value(noisy),
                  (k == 0)       ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0),
                  (k == len - 1) ? ($urandom_range(9) != 0) : ($urandom_range(29) == 0));
      sent += len;
    end
  endtask

  task automatic test_directed();
    // no first mark straight after reset, target zero
    send_item(32'd0, 1'b0, 1'b0);
    send_item(32'd5, 1'b0, 1'b1);
    // repeated prefix sums keep their first position
    send_item(32'd3, 1'b1, 1'b0);
    send_item(-32'sd3, 1'b0, 1'b0);
    send_item(32'd3, 1'b0, 1'b0);
    send_item(-32'sd3, 1'b0, 1'b0);
    send_item(32'd7, 1'b0, 1'b1);
    // one-item run, first and last together
    send_item(32'd0, 1'b1, 1'b1);
    // most negative target, sums beyond 32 bits
    write_target(32'h8000_0000);
    send_item(32'h7fff_ffff, 1'b1, 1'b0);
    send_item(32'h7fff_ffff, 1'b0, 1'b0);
    send_item(32'd2, 1'b0, 1'b0);
    send_item(32'h8000_0000, 1'b0, 1'b0);
    send_item(32'h8000_0000, 1'b0, 1'b1);
    // most positive target
    write_target(32'h7fff_ffff);
    send_item(32'hffff_ffff, 1'b1, 1'b0);
    send_item(32'h7fff_ffff, 1'b0, 1'b0);
    send_item(32'd1, 1'b0, 1'b0);
    send_item(32'h8000_0000, 1'b0, 1'b0);
    send_item(32'h7fff_ffff, 1'b0, 1'b1);
  endtask

  task automatic test_overflow();
    // all ones: every prefix sum distinct so the table fills completely, the run
    // from position zero reaches the full length, then the sequence overflows
    write_target(32'(lssp_pkg::MAX_LEN));
    for (int k = 0; k < lssp_pkg::MAX_LEN + 2; k++)
      send_item(32'd1, k == 0, k == lssp_pkg::MAX_LEN + 1);
    send_item(32'd4, 1'b0, 1'b0);
    // first mark clears the overflow flag
    send_item(32'hffff_ffff, 1'b1, 1'b1);
  endtask

  task automatic test_random_phase(input logic [31:0] tgt, input int n_items,
                                   input bit no_idle);
    write_target(tgt);
    @(posedge clk);
    quiet = no_idle;
    send_random_runs(n_items);
    @(posedge clk);
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    // receiver stalls while the sender keeps offering, so the input backs up
    write_target(-32'sd2);
    @(posedge clk);
    stall_left = STALL_LEN;
    send_random_runs(30);
  endtask

  task automatic test_pause();
    send_random_runs(20);
    wait_drained();
    send_random_runs(20);
  endtask

  // Receiver: random holds, a long stall on request, none in quiet phases
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else if (quiet) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare each accepted result with the oldest pending one
  always @(posedge clk) begin : check_results
    run_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none pending: best_length %0d overflow %0b last %0b",
                 $time, m_tdata[lssp_pkg::LEN_W-1:0], m_tuser, m_tlast);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata !== {{(16-lssp_pkg::LEN_W){1'b0}}, want.best_len}) begin
          $display("%0t: best_length expected %0d actual %0d (tdata %h)",
                   $time, want.best_len, m_tdata[lssp_pkg::LEN_W-1:0], m_tdata);
          mismatch_count++;
        end
        if (m_tlast !== want.is_last) begin
          $display("%0t: is_last expected %0b actual %0b", $time, want.is_last, m_tlast);
          mismatch_count++;
        end
        if (m_tuser !== want.ovf) begin
          $display("%0t: overflow expected %0b actual %0b", $time, want.ovf, m_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_overflow();
    test_random_phase(32'd0, 50, 1'b0);
    test_random_phase(32'd3, 50, 1'b1);
    test_backpressure();
    test_pause();
    test_random_phase(32'h7fff_ffff, 40, 1'b0);
    test_random_phase(32'h8000_0000, 40, 1'b0);
    test_random_phase($urandom, 30, 1'b0);
    test_random_phase(32'($urandom_range(20)) - 32'd10, 40, 1'b0);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/lssp_pkg.sv
rtl/core/lssp_dp.sv
rtl/core/lssp_ctrl.sv
rtl/core/longest_subarray_sum_prefix_map.sv
verif/longest_subarray_sum_prefix_map_tb.sv
